### design/lane_duplicate_suppression_macros.svh
// Assertion macros shared by the lane duplicate suppression files.
// Depends on nothing.
`ifndef LANE_DUPLICATE_SUPPRESSION_MACROS_SVH
`define LANE_DUPLICATE_SUPPRESSION_MACROS_SVH
// Implication checked on every clock edge outside reset.
`define LDS_ASSERT_IMP(label, clk, rst_n, a, b) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (a) |-> (b)) \
        else $error("lds check failed");
// Implication checked in the cycle after the antecedent.
`define LDS_ASSERT_NEXT(label, clk, rst_n, a, b) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (a) |=> (b)) \
        else $error("lds check failed");
`endif

### design/lds_pkg.sv
// Package for the lane duplicate suppression block: constants, codes and types.
// Depends on nothing.
`default_nettype none
package lds_pkg;
    localparam int MAX_LANES = 16;
    localparam int MAX_ROWS = 512;
    localparam int COLUMN_BITS = 12;
    localparam int LANE_W = $clog2(MAX_LANES);
    localparam int ROW_W = $clog2(MAX_ROWS);
    localparam int ADDR_W = LANE_W + ROW_W;
    localparam logic [10:0] RESET_CLOSE_DISTANCE = 11'd5;
    localparam logic [9:0] RESET_MIN_CLOSE_ROWS = 10'd20;

    localparam logic [1:0] KIND_HEADER = 2'd0;
    localparam logic [1:0] KIND_SAMPLE = 2'd1;
    localparam logic [1:0] KIND_FINISH = 2'd2;

    localparam logic [1:0] REG_CONF_FLOOR = 2'd0;
    localparam logic [1:0] REG_NEAR_LIMIT = 2'd1;
    localparam logic [1:0] REG_MIN_ROWS = 2'd2;

    typedef enum logic [2:0] {
        ST_LOAD,
        ST_PAIR,
        ST_SCAN,
        ST_DRAIN,
        ST_DECIDE,
        ST_EMIT
    } state_t;

    typedef struct packed {
        logic init_keep;
        logic pair_start;
        logic scan_step;
        logic decide;
        logic emit_start;
        logic emit_step;
        logic clear_set;
    } cmd_t;

    typedef struct packed {
        logic pair_done;
        logic scan_empty;
        logic scan_last;
        logic emit_done;
        logic emit_none;
    } status_t;
endpackage
`default_nettype wire

### design/lds_ram.sv
// Generic single-write, single-read RAM with a registered read.
// Depends on nothing.
`default_nettype none
module lds_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  wire logic                     clk,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH)-1:0] waddr,
    input  wire logic [WIDTH-1:0]         wdata,
    input  wire logic [$clog2(DEPTH)-1:0] raddr,
    output logic      [WIDTH-1:0]         rdata
);
    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end
endmodule
`default_nettype wire

### design/lds_datapath.sv
// Datapath: lane header stores, two column memories and the pair scan logic.
// Depends on lds_pkg, lds_ram and lane_duplicate_suppression_macros.svh.
`default_nettype none
`include "lane_duplicate_suppression_macros.svh"
module lds_datapath (
    input  wire logic                  clk,
    input  wire logic                  rst_n,
    input  wire logic                  load_en,
    input  wire logic [1:0]            kind,
    input  wire logic [1:0]            color,
    input  wire logic [15:0]           confidence,
    input  wire logic [8:0]            first_row,
    input  wire logic [9:0]            end_row,
    input  wire logic signed [11:0]    column,
    input  wire logic [15:0]           conf_floor,
    input  wire logic [10:0]           near_limit,
    input  wire logic [9:0]            min_rows,
    input  wire lds_pkg::cmd_t         cmd,
    output lds_pkg::status_t           status,
    output logic [3:0]                 lane_index,
    output logic                       last
);
    import lds_pkg::*;

    logic [LANE_W:0] count_reg;
    logic [ROW_W:0] srow_reg;
    logic [1:0] col_reg [MAX_LANES];
    logic [15:0] conf_reg [MAX_LANES];
    logic [8:0] first_reg [MAX_LANES];
    logic [9:0] end_reg [MAX_LANES];
    logic [MAX_LANES-1:0] keep_reg;
    logic [LANE_W-1:0] i_reg, j_reg, e_reg;
    logic [ROW_W:0] k_reg, hi_reg;
    logic [9:0] n_reg;
    logic v1_reg;

    logic we;
    logic [LANE_W-1:0] cur;
    logic [9:0] row;
    logic signed [COLUMN_BITS-1:0] ra, rb;
    logic [ADDR_W-1:0] wa;
    logic signed [COLUMN_BITS:0] d;
    logic [COLUMN_BITS:0] ad;
    logic [9:0] lo, hi;
    logic [LANE_W:0] i1, j1;

    assign cur = LANE_W'(count_reg - 1'b1);
    assign row = 10'(first_reg[cur]) + 10'(srow_reg);
    assign we = load_en && kind == KIND_SAMPLE && count_reg != 0
                && srow_reg < (ROW_W+1)'(MAX_ROWS) && row < 10'(MAX_ROWS);
    assign wa = {cur, row[ROW_W-1:0]};

    lds_ram #(.WIDTH(COLUMN_BITS), .DEPTH(MAX_LANES*MAX_ROWS)) u_ram_a (
        .clk(clk), .we(we), .waddr(wa), .wdata(column[COLUMN_BITS-1:0]),
        .raddr({i_reg, k_reg[ROW_W-1:0]}), .rdata(ra));
    lds_ram #(.WIDTH(COLUMN_BITS), .DEPTH(MAX_LANES*MAX_ROWS)) u_ram_b (
        .clk(clk), .we(we), .waddr(wa), .wdata(column[COLUMN_BITS-1:0]),
        .raddr({j_reg, k_reg[ROW_W-1:0]}), .rdata(rb));

    assign d = (COLUMN_BITS+1)'(ra) - (COLUMN_BITS+1)'(rb);
    assign ad = d[COLUMN_BITS] ? (COLUMN_BITS+1)'(-d) : (COLUMN_BITS+1)'(d);

    assign i1 = (LANE_W+1)'(i_reg) + 1'b1;
    assign j1 = (LANE_W+1)'(j_reg) + 1'b1;
    always_comb
    begin
        lo = first_reg[i_reg] > first_reg[j_reg] ? 10'(first_reg[i_reg])
                                                 : 10'(first_reg[j_reg]);
        hi = end_reg[i_reg] < end_reg[j_reg] ? end_reg[i_reg] : end_reg[j_reg];
        if (hi > 10'(MAX_ROWS))
        begin
            hi = 10'(MAX_ROWS);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg <= '0;
            srow_reg <= '0;
            keep_reg <= '0;
            v1_reg <= 1'b0;
        end
        else
        begin
            v1_reg <= cmd.scan_step;
            if (load_en && kind == KIND_HEADER)
            begin
                if (count_reg < (LANE_W+1)'(MAX_LANES))
                begin
                    count_reg <= count_reg + 1'b1;
                    srow_reg <= '0;
                end
                else
                begin
                    srow_reg <= (ROW_W+1)'(MAX_ROWS);
                end
            end
            else if (we || (load_en && kind == KIND_SAMPLE && count_reg != 0
                            && srow_reg < (ROW_W+1)'(MAX_ROWS)))
            begin
                srow_reg <= srow_reg + 1'b1;
            end
            if (cmd.clear_set)
            begin
                count_reg <= '0;
                srow_reg <= '0;
            end
            if (cmd.init_keep)
            begin
                for (int q = 0; q < MAX_LANES; q++)
                begin
                    keep_reg[q] <= (LANE_W+1)'(q) < count_reg && conf_reg[q] > conf_floor;
                end
            end
            if (cmd.decide && col_reg[i_reg] == col_reg[j_reg] && n_reg >= min_rows)
            begin
                if (conf_reg[i_reg] > conf_reg[j_reg])
                begin
                    keep_reg[j_reg] <= 1'b0;
                end
                else
                begin
                    keep_reg[i_reg] <= 1'b0;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (load_en && kind == KIND_HEADER && count_reg < (LANE_W+1)'(MAX_LANES))
        begin
            col_reg[LANE_W'(count_reg)] <= color;
            conf_reg[LANE_W'(count_reg)] <= confidence;
            first_reg[LANE_W'(count_reg)] <= first_row;
            end_reg[LANE_W'(count_reg)] <= end_row;
        end
        if (cmd.init_keep)
        begin
            i_reg <= '0;
            j_reg <= LANE_W'(1);
        end
        if (cmd.pair_start)
        begin
            k_reg <= lo[ROW_W:0];
            hi_reg <= hi[ROW_W:0];
            n_reg <= '0;
        end
        if (cmd.scan_step)
        begin
            k_reg <= k_reg + 1'b1;
        end
        if (v1_reg && ad < (COLUMN_BITS+1)'(near_limit))
        begin
            n_reg <= n_reg + 1'b1;
        end
        if (cmd.decide)
        begin
            if (j1 >= count_reg)
            begin
                i_reg <= LANE_W'(i1);
                j_reg <= LANE_W'(i1 + 1'b1);
            end
            else
            begin
                j_reg <= LANE_W'(j1);
            end
        end
        if (cmd.emit_start)
        begin
            e_reg <= '0;
        end
        if (cmd.emit_step)
        begin
            e_reg <= e_reg + 1'b1;
        end
    end

    logic [LANE_W:0] nxt_kept;
    always_comb
    begin
        nxt_kept = '0;
        for (int q = MAX_LANES - 1; q >= 0; q--)
        begin
            if ((LANE_W+1)'(q) > (LANE_W+1)'(e_reg) && (LANE_W+1)'(q) < count_reg
                && keep_reg[q])
            begin
                nxt_kept = 1'b1 << LANE_W;
            end
        end
    end

    assign status.pair_done = (LANE_W+1)'(i_reg) + 1'b1 >= count_reg;
    assign status.scan_empty = lo >= hi;
    assign status.scan_last = k_reg + 1'b1 >= hi_reg;
    assign status.emit_done = (LANE_W+1)'(e_reg) + 1'b1 >= count_reg;
    assign status.emit_none = !keep_reg[e_reg] || (LANE_W+1)'(e_reg) >= count_reg;
    assign lane_index = 4'(e_reg);
    assign last = !nxt_kept[LANE_W];

    `LDS_ASSERT_IMP(a_write_in_range, clk, rst_n, we, count_reg != 0)
    `LDS_ASSERT_IMP(a_count_bound, clk, rst_n, 1'b1,
                    count_reg <= (LANE_W+1)'(MAX_LANES))
    `LDS_ASSERT_NEXT(a_pipe, clk, rst_n, cmd.scan_step, v1_reg)
endmodule
`default_nettype wire

### design/lds_control.sv
// Controller state machine for lane duplicate suppression.
// Depends on lds_pkg and lane_duplicate_suppression_macros.svh.
`default_nettype none
`include "lane_duplicate_suppression_macros.svh"
module lds_control (
    input  wire logic             clk,
    input  wire logic             rst_n,
    input  wire logic             in_valid,
    input  wire logic [1:0]       kind,
    output logic                  in_stall,
    output logic                  load_en,
    output logic                  out_valid,
    input  wire logic             out_stall,
    input  wire lds_pkg::status_t status,
    output lds_pkg::cmd_t         cmd
);
    import lds_pkg::*;

    state_t state_reg, state_next;
    logic [1:0] drain_reg, drain_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_LOAD;
            drain_reg <= '0;
        end
        else
        begin
            state_reg <= state_next;
            drain_reg <= drain_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        drain_next = drain_reg;
        cmd = '0;
        in_stall = 1'b1;
        load_en = 1'b0;
        out_valid = 1'b0;
        case (state_reg)
            ST_LOAD:
            begin
                in_stall = 1'b0;
                load_en = in_valid && kind != KIND_FINISH;
                if (in_valid && kind == KIND_FINISH)
                begin
                    cmd.init_keep = 1'b1;
                    state_next = ST_PAIR;
                end
            end
            ST_PAIR:
            begin
                if (status.pair_done)
                begin
                    cmd.emit_start = 1'b1;
                    state_next = ST_EMIT;
                end
                else
                begin
                    cmd.pair_start = 1'b1;
                    state_next = ST_SCAN;
                end
            end
            ST_SCAN:
            begin
                if (status.scan_empty)
                begin
                    state_next = ST_DECIDE;
                end
                else
                begin
                    cmd.scan_step = 1'b1;
                    if (status.scan_last)
                    begin
                        drain_next = 2'd3;
                        state_next = ST_DRAIN;
                    end
                end
            end
            ST_DRAIN:
            begin
                drain_next = drain_reg - 1'b1;
                if (drain_reg == 2'd1)
                begin
                    state_next = ST_DECIDE;
                end
            end
            ST_DECIDE:
            begin
                cmd.decide = 1'b1;
                state_next = ST_PAIR;
            end
            ST_EMIT:
            begin
                out_valid = !status.emit_none;
                if (status.emit_none || !out_stall)
                begin
                    if (status.emit_done)
                    begin
                        cmd.clear_set = 1'b1;
                        state_next = ST_LOAD;
                    end
                    else
                    begin
                        cmd.emit_step = 1'b1;
                    end
                end
            end
            default:
            begin
                state_next = ST_LOAD;
            end
        endcase
    end

    `LDS_ASSERT_IMP(a_no_load_busy, clk, rst_n, state_reg != ST_LOAD, in_stall)
    `LDS_ASSERT_IMP(a_out_only_emit, clk, rst_n, out_valid, state_reg == ST_EMIT)
    `LDS_ASSERT_NEXT(a_finish, clk, rst_n, cmd.init_keep, state_reg == ST_PAIR)
endmodule
`default_nettype wire

### design/lane_duplicate_suppression.sv
// Top level of lane duplicate suppression: APB registers, controller and datapath.
// Depends on lds_pkg, lds_control and lds_datapath.
//
// Input words are headers, column samples or a finish word, taken on the
// in_valid/in_stall channel. Headers and samples are taken one per cycle.
// A finish word starts validation; the input stalls until all results are out.
// Validation walks each lane pair through the pair, scan, drain and decide
// states; a pair with no shared rows skips drain, and a last pair state ends
// the walk. Kept lanes then leave on out_valid/out_stall one per cycle while not
// stalled, in load order, with last on the final one; each dropped lane takes
// an emit step. A stalled result holds until taken. After reset the set is
// empty and the registers hold their reset values; the column memory needs no
// clearing. Registers sit at byte addresses 0, 4 and 8; the user must see that
// they are written only when idle, as the block does not enforce it.
`default_nettype none
module lane_duplicate_suppression (
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire logic               in_valid,
    output logic                    in_stall,
    input  wire logic [1:0]         kind,
    input  wire logic [1:0]         color,
    input  wire logic [15:0]        confidence,
    input  wire logic [8:0]         first_row,
    input  wire logic [9:0]         end_row,
    input  wire logic signed [11:0] column,
    output logic                    out_valid,
    input  wire logic               out_stall,
    output logic [3:0]              lane_index,
    output logic                    last,
    input  wire logic               psel,
    input  wire logic               penable,
    input  wire logic               pwrite,
    input  wire logic [3:0]         paddr,
    input  wire logic [31:0]        pwdata,
    output logic [31:0]             prdata,
    output logic                    pready
);
    import lds_pkg::*;

    logic [15:0] conf_floor_reg;
    logic [10:0] near_limit_reg;
    logic [9:0] min_rows_reg;
    logic load_en;
    cmd_t cmd;
    status_t status;

    assign pready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            conf_floor_reg <= '0;
            near_limit_reg <= RESET_CLOSE_DISTANCE;
            min_rows_reg <= RESET_MIN_CLOSE_ROWS;
        end
        else if (psel && penable && pwrite)
        begin
            case (paddr[3:2])
                REG_CONF_FLOOR: conf_floor_reg <= pwdata[15:0];
                REG_NEAR_LIMIT: near_limit_reg <= pwdata[10:0];
                REG_MIN_ROWS: min_rows_reg <= pwdata[9:0];
                default: ;
            endcase
        end
    end

    always_comb
    begin
        case (paddr[3:2])
            REG_CONF_FLOOR: prdata = 32'(conf_floor_reg);
            REG_NEAR_LIMIT: prdata = 32'(near_limit_reg);
            REG_MIN_ROWS: prdata = 32'(min_rows_reg);
            default: prdata = '0;
        endcase
    end

    lds_control u_control (
        .clk(clk), .rst_n(rst_n), .in_valid(in_valid), .kind(kind),
        .in_stall(in_stall), .load_en(load_en), .out_valid(out_valid),
        .out_stall(out_stall), .status(status), .cmd(cmd));

    lds_datapath u_datapath (
        .clk(clk), .rst_n(rst_n), .load_en(load_en), .kind(kind), .color(color),
        .confidence(confidence), .first_row(first_row), .end_row(end_row),
        .column(column), .conf_floor(conf_floor_reg), .near_limit(near_limit_reg),
        .min_rows(min_rows_reg), .cmd(cmd), .status(status),
        .lane_index(lane_index), .last(last));
endmodule
`default_nettype wire

### tb/sv/tb_top.sv
// Self-checking testbench for lane_duplicate_suppression: loads lane sets, predicts
// the kept lanes of every finish word and compares them with the result channel.
// Depends on lds_pkg and the lane_duplicate_suppression RTL.
module tb_top;
    import lds_pkg::*;

    localparam int LIMIT = 3000000;
    localparam int SETTLE = 2000;

    typedef struct packed {
        logic [1:0]  kind;
        logic [1:0]  color;
        logic [15:0] confidence;
        logic [8:0]  first_row;
        logic [9:0]  end_row;
        logic [11:0] column;
    } lane_word_t;

    typedef struct packed {
        logic [3:0] lane_index;
        logic       last;
    } kept_lane_t;

    logic clk = 1'b0;
    logic rst_n = 1'b0;
    logic in_valid = 1'b0;
    logic in_stall;
    logic [1:0] kind = '0;
    logic [1:0] color = '0;
    logic [15:0] confidence = '0;
    logic [8:0] first_row = '0;
    logic [9:0] end_row = '0;
    logic signed [11:0] column = '0;
    logic out_valid;
    logic out_stall = 1'b0;
    logic [3:0] lane_index;
    logic last;
    logic psel = 1'b0;
    logic penable = 1'b0;
    logic pwrite = 1'b0;
    logic [3:0] paddr = '0;
    logic [31:0] pwdata = '0;
    logic [31:0] prdata;
    logic pready;

    lane_word_t pending_words[$];
    kept_lane_t kept_expected[$];

    int errors = 0;
    int cycles = 0;
    int words_taken = 0;
    int lanes_seen = 0;
    int sets_done = 0;
    int gap_left = 0;
    bit sender_gaps = 1'b1;
    bit hold_request = 1'b0;
    int hold_left = 0;

    logic [15:0] cfg_conf_floor = 16'd0;
    logic [10:0] cfg_close = RESET_CLOSE_DISTANCE;
    logic [9:0]  cfg_rows = RESET_MIN_CLOSE_ROWS;

    int ln_count = 0;
    int ln_row = 0;
    logic [1:0]  ln_color[MAX_LANES];
    logic [15:0] ln_conf[MAX_LANES];
    int ln_first[MAX_LANES];
    int ln_end[MAX_LANES];
    int ln_col[MAX_LANES][MAX_ROWS];
    int set_base[MAX_ROWS];

    lane_duplicate_suppression u_top (
        .clk(clk), .rst_n(rst_n),
        .in_valid(in_valid), .in_stall(in_stall),
        .kind(kind), .color(color), .confidence(confidence),
        .first_row(first_row), .end_row(end_row), .column(column),
        .out_valid(out_valid), .out_stall(out_stall),
        .lane_index(lane_index), .last(last),
        .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
        .pwdata(pwdata), .prdata(prdata), .pready(pready)
    );

    always
    begin
        #6 clk = 1'b1;
        #6 clk = 1'b0;
    end

    task automatic report(input string what);
        $display("mismatch at cycle %0d: %s", cycles, what);
        errors++;
    endtask

    function automatic int close_rows(input int a, input int b);
        int lo;
        int hi;
        int n;
        int d;
        lo = ln_first[a] > ln_first[b] ? ln_first[a] : ln_first[b];
        hi = ln_end[a] < ln_end[b] ? ln_end[a] : ln_end[b];
        n = 0;
        if (hi > MAX_ROWS)
            hi = MAX_ROWS;
        for (int k = lo; k < hi; k++)
        begin
            d = ln_col[a][k] - ln_col[b][k];
            if (d < 0)
                d = -d;
            if (d < int'(cfg_close))
                n++;
        end
        return n;
    endfunction

    task automatic predict_kept(input lane_word_t w);
        bit keep[MAX_LANES];
        int row;
        int n;
        int last_pos;
        kept_lane_t r;
        if (w.kind == KIND_HEADER)
        begin
            if (ln_count < MAX_LANES)
            begin
                ln_color[ln_count] = w.color;
                ln_conf[ln_count] = w.confidence;
                ln_first[ln_count] = w.first_row;
                ln_end[ln_count] = w.end_row;
                for (int k = 0; k < MAX_ROWS; k++)
                    ln_col[ln_count][k] = 0;
                ln_count++;
                ln_row = 0;
                lanes_seen++;
            end
            else
                ln_row = MAX_ROWS;
        end
        else if (w.kind == KIND_SAMPLE)
        begin
            if (ln_count != 0 && ln_row < MAX_ROWS)
            begin
                row = ln_first[ln_count - 1] + ln_row;
                if (row < MAX_ROWS)
                    ln_col[ln_count - 1][row] = $signed(w.column);
                ln_row++;
            end
        end
        else if (w.kind == KIND_FINISH)
        begin
            for (int i = 0; i < MAX_LANES; i++)
                keep[i] = i < ln_count && ln_conf[i] > cfg_conf_floor;
            for (int i = 0; i < ln_count; i++)
                for (int j = i + 1; j < ln_count; j++)
                    if (ln_color[i] == ln_color[j] && close_rows(i, j) >= int'(cfg_rows))
                    begin
                        if (ln_conf[i] > ln_conf[j])
                            keep[j] = 1'b0;
                        else
                            keep[i] = 1'b0;
                    end
            n = 0;
            last_pos = kept_expected.size();
            for (int i = 0; i < ln_count; i++)
                if (keep[i])
                begin
                    r.lane_index = i[3:0];
                    r.last = 1'b0;
                    last_pos = kept_expected.size();
                    kept_expected = {kept_expected, r};
                    n++;
                end
            if (n > 0)
                kept_expected[last_pos].last = 1'b1;
            ln_count = 0;
            ln_row = 0;
            sets_done++;
        end
    endtask

    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (cycles > LIMIT)
        begin
            $display("timeout after %0d cycles", cycles);
            $display("CHECKS FAILED");
            $finish;
        end
    end

    // Sender: holds a stalled word, otherwise idles or offers the next one.
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (in_valid && !in_stall)
            begin
                predict_kept('{kind, color, confidence, first_row, end_row, column});
                words_taken++;
            end
            if (!in_valid || !in_stall)
            begin
                if (gap_left > 0)
                begin
                    gap_left <= gap_left - 1;
                    in_valid <= 1'b0;
                end
                else if (pending_words.size() > 0)
                begin
                    lane_word_t w;
                    int p;
                    w = pending_words.pop_front();
                    kind <= w.kind;
                    color <= w.color;
                    confidence <= w.confidence;
                    first_row <= w.first_row;
                    end_row <= w.end_row;
                    column <= w.column;
                    in_valid <= 1'b1;
                    p = $urandom_range(0, 99);
                    if (!sender_gaps || p < 65)
                        gap_left <= 0;
                    else if (p < 95)
                        gap_left <= $urandom_range(1, 3);
                    else
                        gap_left <= $urandom_range(10, 40);
                end
                else
                    in_valid <= 1'b0;
            end
        end
    end

    // Receiver: checks each taken result and stalls at random.
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (out_valid && !out_stall)
            begin
                if (kept_expected.size() == 0)
                    report($sformatf("unexpected result lane %0d", lane_index));
                else
                begin
                    kept_lane_t e;
                    e = kept_expected.pop_front();
                    if (lane_index !== e.lane_index)
                        report($sformatf("lane_index %0d, expected %0d", lane_index,
                                         e.lane_index));
                    if (last !== e.last)
                        report($sformatf("last %0b, expected %0b on lane %0d", last,
                                         e.last, e.lane_index));
                end
            end
            if (hold_left > 0)
            begin
                hold_left <= hold_left - 1;
                out_stall <= 1'b1;
            end
            else if (hold_request)
            begin
                hold_request <= 1'b0;
                hold_left <= 400;
                out_stall <= 1'b1;
            end
            else
            begin
                int p;
                p = $urandom_range(0, 99);
                if (p < 3)
                begin
                    hold_left <= $urandom_range(10, 60);
                    out_stall <= 1'b1;
                end
                else
                    out_stall <= p < 25;
            end
        end
    end

    task automatic add_word(input logic [1:0] k, input logic [1:0] c, input logic [15:0] cf,
                            input logic [8:0] fr, input logic [9:0] er,
                            input logic [11:0] col);
        lane_word_t w;
        w = '{k, c, cf, fr, er, col};
        pending_words = {pending_words, w};
    endtask

    // A lane whose samples cover every row it can be compared on.
    task automatic add_lane(input logic [1:0] c, input logic [15:0] cf, input int fr,
                            input int er, input int extra, input bit near);
        int rows;
        int v;
        add_word(KIND_HEADER, c, cf, fr[8:0], er[9:0], 12'($urandom));
        rows = (er > MAX_ROWS ? MAX_ROWS : er) - fr;
        if (rows < 0)
            rows = 0;
        for (int k = 0; k < rows + extra; k++)
        begin
            if (near && fr + k < MAX_ROWS)
                v = set_base[fr + k] + $urandom_range(0, 14) - 7;
            else
                v = $urandom;
            add_word(KIND_SAMPLE, 2'($urandom), 16'($urandom), 9'($urandom),
                     10'($urandom), v[11:0]);
        end
    endtask

    task automatic random_set(input int max_lanes, input int max_span);
        int n;
        int fr;
        int sp;
        logic [15:0] prev;
        n = $urandom_range(1, max_lanes);
        prev = 16'($urandom);
        for (int k = 0; k < MAX_ROWS; k++)
            set_base[k] = $urandom;
        if ($urandom_range(0, 9) == 0)
            add_word(KIND_SAMPLE, 2'd0, 16'd0, 9'd0, 10'd0, 12'($urandom));
        for (int i = 0; i < n; i++)
        begin
            fr = $urandom_range(0, 30);
            sp = $urandom_range(0, max_span);
            if ($urandom_range(0, 3) != 0)
                prev = 16'($urandom);
            if ($urandom_range(0, 7) == 0)
                add_lane(2'($urandom_range(0, 3)), prev, fr, fr - $urandom_range(0, fr), 0,
                         1'b0);
            else
                add_lane(2'($urandom_range(0, 1)), prev, fr, fr + sp, $urandom_range(0, 2),
                         $urandom_range(0, 3) != 0);
            if ($urandom_range(0, 15) == 0)
                add_word(2'd3, 2'($urandom), 16'($urandom), 9'($urandom), 10'($urandom),
                         12'($urandom));
        end
        add_word(KIND_FINISH, 2'($urandom), 16'($urandom), 9'($urandom), 10'($urandom),
                 12'($urandom));
    endtask

    task automatic wait_idle();
        while (pending_words.size() > 0 || in_valid || gap_left > 0 ||
               kept_expected.size() > 0)
            @(posedge clk);
        repeat (SETTLE) @(posedge clk);
    endtask

    task automatic reg_write(input logic [1:0] idx, input logic [31:0] value);
        @(posedge clk);
        psel <= 1'b1;
        penable <= 1'b0;
        pwrite <= 1'b1;
        paddr <= {idx, 2'b00};
        pwdata <= value;
        @(posedge clk);
        penable <= 1'b1;
        @(posedge clk);
        psel <= 1'b0;
        penable <= 1'b0;
        pwrite <= 1'b0;
        case (idx)
            REG_CONF_FLOOR: cfg_conf_floor = value[15:0];
            REG_NEAR_LIMIT: cfg_close = value[10:0];
            REG_MIN_ROWS:   cfg_rows = value[9:0];
            default: ;
        endcase
    endtask

    task automatic set_config(input logic [15:0] mc, input logic [10:0] cd,
                              input logic [9:0] mr);
        wait_idle();
        reg_write(REG_CONF_FLOOR, {16'd0, mc});
        reg_write(REG_NEAR_LIMIT, {21'd0, cd});
        reg_write(REG_MIN_ROWS, {22'd0, mr});
    endtask

    initial
    begin
        repeat (7) @(posedge clk);
        rst_n <= 1'b1;

        // Directed: edge rows, a confidence tie, stray words and an empty finish.
        for (int k = 0; k < MAX_ROWS; k++)
            set_base[k] = 12'h7ff - (k % 3);
        add_word(KIND_SAMPLE, 2'd3, 16'hffff, 9'h1ff, 10'h3ff, 12'h800);
        add_word(KIND_FINISH, 2'd0, 16'd0, 9'd0, 10'd0, 12'd0);
        add_lane(2'd3, 16'hffff, 500, 512, 1, 1'b1);
        add_lane(2'd3, 16'hffff, 505, 1023, 3, 1'b1);
        add_lane(2'd2, 16'h0000, 0, 0, 0, 1'b0);
        add_word(2'd3, 2'd3, 16'hffff, 9'h1ff, 10'h3ff, 12'hfff);
        add_word(KIND_FINISH, 2'd1, 16'h1234, 9'd7, 10'd9, 12'd1);
        for (int i = 0; i <= MAX_LANES; i++)
            add_word(KIND_HEADER, 2'(i % 2), 16'(i * 1000 + 1), 9'(i), 10'(i), 12'd0);
        add_word(KIND_SAMPLE, 2'd0, 16'd0, 9'd0, 10'd0, 12'h555);
        add_word(KIND_FINISH, 2'd0, 16'd0, 9'd0, 10'd0, 12'd0);
        wait_idle();

        // Every same-colour pair duplicates, wide distance, high threshold.
        set_config(16'h8000, 11'd2047, 10'd0);
        for (int i = 0; i < 4; i++)
            random_set(5, 12);
        for (int i = 0; i < 6; i++)
            add_word(KIND_HEADER, 2'(i % 3), 16'(i * 13000), 9'd3, 10'd2, 12'd0);
        add_word(KIND_FINISH, 2'd0, 16'd0, 9'd0, 10'd0, 12'd0);

        set_config(16'hffff, 11'd0, 10'd512);
        for (int i = 0; i < 3; i++)
            random_set(4, 10);

        // Long receiver hold while the sender keeps offering words.
        set_config(16'h0100, 11'd8, 10'd3);
        sender_gaps = 1'b0;
        hold_request = 1'b1;
        for (int i = 0; i < 4; i++)
            random_set(6, 20);
        wait_idle();
        sender_gaps = 1'b1;

        while (words_taken < 450)
        begin
            set_config(16'($urandom_range(0, 3) == 0 ? $urandom : $urandom_range(0, 255)),
                       11'($urandom_range(0, 20)), 10'($urandom_range(0, 12)));
            for (int i = 0; i < 3; i++)
                random_set(5, 25);
        end
        wait_idle();

        $display("Took %0d words: %0d lanes in %0d sets over %0d cycles.", words_taken,
                 lanes_seen, sets_done, cycles);
        $display("Covered edge rows, lane overflow, ties and extreme register settings.");
        if (errors == 0)
            $display("ALL CHECKS PASSED");
        else
            $display("CHECKS FAILED");
        $finish;
    end
endmodule

### lane_duplicate_suppression.f
+incdir+design
design/lds_pkg.sv
design/lds_ram.sv
design/lds_datapath.sv
design/lds_control.sv
design/lane_duplicate_suppression.sv
tb/sv/tb_top.sv
